@@ src/pica_pkg.sv @@
// shared types, register indexes and fixed-point helpers for the pi controller
`timescale 1ns / 1ps

package pica_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [2:0] REG_OUT_UPPER     = 3'd2;
    localparam logic [2:0] REG_OUT_LOWER     = 3'd3;
    localparam logic [2:0] REG_CLAMP_ENABLE  = 3'd4;
    localparam logic [2:0] REG_WINDUP_ENABLE = 3'd5;
    localparam logic [2:0] REG_WINDUP_GAIN   = 3'd6;

    // operand pairs for the shared multiplier
    typedef logic [1:0] mul_sel_t;
    localparam mul_sel_t MUL_KI_ERR = 2'd0;
    localparam mul_sel_t MUL_KP_ERR = 2'd1;
    localparam mul_sel_t MUL_WG_DIF = 2'd2;

    localparam logic signed [31:0] OUT_UPPER_RST = 32'sd65536;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic     load_in;
        logic     clr_integ;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     upd_integ;
        logic     upd_raw;
        logic     load_out;
        logic     upd_windup;
    } pica_cmd_t;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if ((&v[33:31]) || (~|v[33:31])) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // q16.16 product scaling: add half, floor shift by 16, saturate
    function automatic logic signed [31:0] q_scale(input logic signed [63:0] p);
        logic signed [63:0] t;
        logic signed [47:0] s;
        logic signed [31:0] r;
        t = p + 64'sh8000;
        s = t[63:16];
        if ((&s[47:31]) || (~|s[47:31])) begin
            r = s[31:0];
        end else if (s[47]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

@@ src/pica_ctrl.sv @@
// sequencer for the pi controller: steps one sample through the datapath
`timescale 1ns / 1ps

module pica_ctrl import pica_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_clear_integral,
    output logic      m_valid,
    input  logic      m_ready,
    output pica_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_I = 3'd1;
    localparam logic [2:0] ST_INTEG = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_CLAMP = 3'd4;
    localparam logic [2:0] ST_MUL_W = 3'd5;
    localparam logic [2:0] ST_WIND  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_KI_ERR;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in   = 1'b1;
                    cmd.clr_integ = s_clear_integral;
                    state_next    = s_clear_integral ? ST_CLAMP : ST_MUL_I;
                end
            end
            ST_MUL_I: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KI_ERR;
                state_next  = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.upd_integ = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_KP_ERR;
                state_next    = ST_SUM;
            end
            ST_SUM: begin
                cmd.upd_raw = 1'b1;
                state_next  = ST_CLAMP;
            end
            ST_CLAMP: begin
                // hold here while the previous result is still unread
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_MUL_W;
                end
            end
            ST_MUL_W: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WG_DIF;
                state_next  = ST_WIND;
            end
            ST_WIND: begin
                cmd.upd_windup = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/pica_dp.sv @@
// datapath for the pi controller: settings, loop state and shared multiplier
`timescale 1ns / 1ps

module pica_dp import pica_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] s_reference,
    input  logic signed [31:0] s_measured,
    input  pica_cmd_t          cmd,
    output logic signed [31:0] m_drive,
    output logic signed [31:0] m_unclamped
);

    logic signed [31:0] prop_gain_reg, integ_gain_reg, out_upper_reg, out_lower_reg;
    logic signed [31:0] windup_gain_reg;
    logic               clamp_enable_reg, windup_enable_reg;

    logic signed [31:0] err_reg, diff_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] integ_reg, raw_reg, windup_reg;
    logic signed [31:0] drive_reg, unclamped_reg;

    logic signed [31:0] err_next, mul_a, mul_b, prod_q;
    logic signed [31:0] integ_next, raw_next, drive_c, diff_next, windup_next;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            out_upper_reg     <= OUT_UPPER_RST;
            out_lower_reg     <= '0;
            clamp_enable_reg  <= 1'b0;
            windup_enable_reg <= 1'b0;
            windup_gain_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                REG_INTEG_GAIN:    integ_gain_reg    <= cfg_data;
                REG_OUT_UPPER:     out_upper_reg     <= cfg_data;
                REG_OUT_LOWER:     out_lower_reg     <= cfg_data;
                REG_CLAMP_ENABLE:  clamp_enable_reg  <= cfg_data[0];
                REG_WINDUP_ENABLE: windup_enable_reg <= cfg_data[0];
                REG_WINDUP_GAIN:   windup_gain_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign err_next = sat34({{2{s_reference[31]}}, s_reference}
                          - {{2{s_measured[31]}}, s_measured});

    // shared multiplier operands
    always_comb begin
        case (cmd.mul_sel)
            MUL_KI_ERR: begin
                mul_a = integ_gain_reg;
                mul_b = err_reg;
            end
            MUL_KP_ERR: begin
                mul_a = prop_gain_reg;
                mul_b = err_reg;
            end
            MUL_WG_DIF: begin
                mul_a = windup_gain_reg;
                mul_b = diff_reg;
            end
            default: begin
                mul_a = windup_gain_reg;
                mul_b = diff_reg;
            end
        endcase
    end

    assign prod_q = q_scale(prod_reg);

    assign integ_next = sat34({{2{integ_reg[31]}}, integ_reg}
                            + {{2{prod_q[31]}}, prod_q}
                            + {{2{windup_reg[31]}}, windup_reg});
    assign raw_next   = sat34({{2{prod_q[31]}}, prod_q} + {{2{integ_reg[31]}}, integ_reg});

    // upper limit tested first, so it wins for a value above upper and below lower
    always_comb begin
        drive_c = raw_reg;
        if (clamp_enable_reg) begin
            if (raw_reg > out_upper_reg) begin
                drive_c = out_upper_reg;
            end else if (raw_reg < out_lower_reg) begin
                drive_c = out_lower_reg;
            end
        end
    end

    assign diff_next   = sat34({{2{drive_c[31]}}, drive_c} - {{2{raw_reg[31]}}, raw_reg});
    assign windup_next = (clamp_enable_reg && windup_enable_reg) ? prod_q : '0;

    // operand and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            err_reg <= err_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        if (cmd.load_out) begin
            drive_reg     <= drive_c;
            unclamped_reg <= raw_reg;
            diff_reg      <= diff_next;
        end
    end

    // loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg  <= '0;
            raw_reg    <= '0;
            windup_reg <= '0;
        end else begin
            if (cmd.clr_integ) begin
                integ_reg <= '0;
            end else if (cmd.upd_integ) begin
                integ_reg <= integ_next;
            end
            if (cmd.upd_raw) begin
                raw_reg <= raw_next;
            end
            if (cmd.upd_windup) begin
                windup_reg <= windup_next;
            end
        end
    end

    assign m_drive     = drive_reg;
    assign m_unclamped = unclamped_reg;

endmodule

@@ src/pi_controller_antiwindup.sv @@
// top level of the pi controller with back-calculation anti-windup
`timescale 1ns / 1ps

// channel   | handshake              | payload
// ----------+------------------------+--------------------------------------------
// input     | s_valid / s_ready      | s_reference, s_measured, s_clear_integral
// result    | m_valid / m_ready      | m_drive, m_unclamped
// settings  | cfg_wr_en (no wait)    | cfg_index, cfg_data
//
// a normal beat takes the sequencer through mul_i, integ, sum, clamp, mul_w and
// wind before s_ready returns; a clear beat runs only clamp, mul_w and wind. the
// result is registered in the clamp step, and a new beat is taken only once the
// last one is through. the single 32x32 multiplier is used in turn for ki*err,
// kp*err and the anti-windup product.
// s_ready is high only while the sequencer is idle; a pending unread result
// does not block the next beat, but the clamp step waits until the output
// register is free. reset (aresetn low, synchronous) clears the loop state and
// restores the register defaults.

module pi_controller_antiwindup import pica_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // settings write port
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // sample input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_reference,
    input  logic signed [31:0] s_measured,
    input  logic               s_clear_integral,
    // controller output
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_drive,
    output logic signed [31:0] m_unclamped
);

    // step commands from the sequencer
    pica_cmd_t cmd;

    // sequencer: multiply, integrate, sum, clamp, windup; a clear starts at clamp
    pica_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_clear_integral (s_clear_integral),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .cmd              (cmd)
    );

    // datapath: settings registers, integrator, clamp and the shared multiplier
    pica_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_reference (s_reference),
        .s_measured  (s_measured),
        .cmd         (cmd),
        .m_drive     (m_drive),
        .m_unclamped (m_unclamped)
    );

    // a result is never written over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("result register loaded while previous beat unread");

    // one beat in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a beat is in flight");

    // loading the result always raises valid
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("result loaded but not presented");

    // integrator update, output load and windup update are separate steps
    a_steps_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.upd_integ, cmd.load_out, cmd.upd_windup}))
        else $error("overlapping sequencer steps");

endmodule

@@ tb/pi_controller_antiwindup_tb.sv @@
// self-checking testbench for the pi controller with back-calculation anti-windup
`timescale 1ns / 1ps

module pi_controller_antiwindup_tb;
    import pica_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int SETTLE_CYCLES = 12;      // margin for the sequencer to finish its last beat
    localparam int CYCLE_LIMIT   = 500000;  // run limit; a correct run ends well before it
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_BEATS   = 115;

    // index with no register behind it, writes must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam longint             L_MAX = 64'sd2147483647;
    localparam longint             L_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [31:0] unclamped;
    } loop_out_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_reference;
    logic signed [31:0] s_measured;
    logic               s_clear_integral;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_drive;
    logic signed [31:0] m_unclamped;

    // loop settings as the block should hold them
    logic signed [31:0] kp, ki, hi_lim, lo_lim, aw_gain;
    logic               clamp_on, aw_on;
    // loop state of the predictor
    logic signed [31:0] integ_acc, raw_out, aw_term;

    loop_out_t   pending_outputs[$];
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned send_calm;
    int unsigned recv_calm;

    pi_controller_antiwindup u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_reference      (s_reference),
        .s_measured       (s_measured),
        .s_clear_integral (s_clear_integral),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive          (m_drive),
        .m_unclamped      (m_unclamped)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // fixed-point helpers for the predictor
    // ------------------------------------------------------------------

    // saturate an exact sum to the signed 32-bit range
    function automatic logic signed [31:0] clip32(input longint v);
        logic signed [31:0] r;
        if (v > L_MAX) begin
            r = Q_MAX;
        end else if (v < L_MIN) begin
            r = Q_MIN;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    // q16.16 product, round half up, floor shift, saturate
    function automatic logic signed [31:0] fixmul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return clip32(p >>> 16);
    endfunction

    // one loop update; returns what the block must emit for this beat
    function automatic loop_out_t predict_controller(input logic signed [31:0] r,
                                                     input logic signed [31:0] m,
                                                     input logic clr);
        logic signed [31:0] err;
        loop_out_t          res;
        if (clr) begin
            // clear only drops the integrator, the last raw output is re-clamped
            integ_acc = '0;
        end else begin
            err       = clip32(longint'(r) - longint'(m));
            integ_acc = clip32(longint'(integ_acc) + longint'(fixmul(ki, err))
                               + longint'(aw_term));
            raw_out   = clip32(longint'(fixmul(kp, err)) + longint'(integ_acc));
        end
        if (clamp_on) begin
            // upper bound wins when raw is above it and also below the lower bound
            if (raw_out > hi_lim) begin
                res.drive = hi_lim;
            end else if (raw_out < lo_lim) begin
                res.drive = lo_lim;
            end else begin
                res.drive = raw_out;
            end
            if (aw_on) begin
                aw_term = fixmul(clip32(longint'(res.drive) - longint'(raw_out)), aw_gain);
            end else begin
                aw_term = '0;
            end
        end else begin
            // anti-windup has no effect without the clamp
            res.drive = raw_out;
            aw_term   = '0;
        end
        res.unclamped = raw_out;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // monitor: mirror settings writes, predict accepted beats, check results
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        loop_out_t want;
        if (!aresetn) begin
            kp        = '0;
            ki        = '0;
            hi_lim    = OUT_UPPER_RST;
            lo_lim    = '0;
            clamp_on  = 1'b0;
            aw_on     = 1'b0;
            aw_gain   = '0;
            integ_acc = '0;
            raw_out   = '0;
            aw_term   = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_outputs.size() == 0) begin
                    $error("result beat with nothing expected: drive %0d, unclamped %0d",
                           m_drive, m_unclamped);
                    fail_count++;
                end else begin
                    want = pending_outputs.pop_front();
                    if (m_drive !== want.drive) begin
                        $error("drive mismatch: expected %0d, got %0d", want.drive, m_drive);
                        fail_count++;
                    end
                    if (m_unclamped !== want.unclamped) begin
                        $error("unclamped mismatch: expected %0d, got %0d",
                               want.unclamped, m_unclamped);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PROP_GAIN:     kp       = cfg_data;
                    REG_INTEG_GAIN:    ki       = cfg_data;
                    REG_OUT_UPPER:     hi_lim   = cfg_data;
                    REG_OUT_LOWER:     lo_lim   = cfg_data;
                    REG_CLAMP_ENABLE:  clamp_on = cfg_data[0];
                    REG_WINDUP_ENABLE: aw_on    = cfg_data[0];
                    REG_WINDUP_GAIN:   aw_gain  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pending_outputs.push_back(
                    predict_controller(s_reference, s_measured, s_clear_integral));
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // pacing: random per-beat waits, with occasional calm stretches
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned g;
        if (calm != 0) begin
            calm--;
            g = 0;
        end else if ($urandom_range(0, 39) == 0) begin
            // start a stretch of back-to-back beats
            calm = $urandom_range(10, 40);
            g = 0;
        end else begin
            g = $urandom_range(0, 18);
        end
        return g;
    endfunction

    // result side: stall a random number of cycles, then hold ready until a beat moves
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = pick_gap(recv_calm);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid));
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // present one sample beat and hold it until accepted
    task automatic send_sample(input logic signed [31:0] r, input logic signed [31:0] m,
                               input logic clr);
        int unsigned gap;
        @(negedge aclk);
        gap = pick_gap(send_calm);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_reference      = r;
        s_measured       = m;
        s_clear_integral = clr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid, wait for every expected result, then let the sequencer finish
    task automatic wait_loop_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_outputs.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // full set of loop settings, only ever applied with the block idle
    task automatic load_settings(input logic signed [31:0] p_gain, input logic signed [31:0] i_gain,
                                 input logic signed [31:0] upper, input logic signed [31:0] lower,
                                 input logic clamp, input logic windup,
                                 input logic signed [31:0] w_gain);
        wait_loop_idle();
        write_reg(REG_PROP_GAIN, p_gain);
        write_reg(REG_INTEG_GAIN, i_gain);
        write_reg(REG_OUT_UPPER, upper);
        write_reg(REG_OUT_LOWER, lower);
        write_reg(REG_CLAMP_ENABLE, {31'd0, clamp});
        write_reg(REG_WINDUP_ENABLE, {31'd0, windup});
        write_reg(REG_WINDUP_GAIN, w_gain);
    endtask

    // ------------------------------------------------------------------
    // random value sources
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] pick_extreme();
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = Q_MAX;
            1:       v = Q_MIN;
            2:       v = '0;
            default: v = -32'sd1;
        endcase
        return v;
    endfunction

    // samples: mostly within +-64.0, some full-range words and extremes
    function automatic logic signed [31:0] pick_sample();
        logic signed [31:0] v;
        int unsigned        k;
        k = $urandom_range(0, 9);
        if (k == 0) begin
            v = pick_extreme();
        end else if (k <= 2) begin
            v = $urandom();
        end else begin
            v = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        end
        return v;
    endfunction

    // gains: mostly within +-4.0
    function automatic logic signed [31:0] pick_gain();
        logic signed [31:0] v;
        int unsigned        k;
        k = $urandom_range(0, 7);
        if (k == 0) begin
            v = pick_extreme();
        end else if (k == 1) begin
            v = $urandom();
        end else begin
            v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // register defaults: zero gains, then the default clamp window of [0, 1.0]
    task automatic test_power_up_defaults();
        send_sample(32'sh0003_0000, 32'sh0001_0000, 1'b0);
        send_sample(Q_MAX, Q_MIN, 1'b0);
        wait_loop_idle();
        write_reg(REG_PROP_GAIN, Q_ONE);
        write_reg(REG_CLAMP_ENABLE, 32'd1);
        send_sample(32'sh0005_0000, '0, 1'b0);
        send_sample(-32'sh0005_0000, '0, 1'b0);
    endtask

    // saturation at every stage with the largest gains and an open window
    task automatic test_saturating_extremes();
        load_settings(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1, 1'b1, Q_MAX);
        send_sample(Q_MAX, Q_MIN, 1'b0);
        send_sample(Q_MIN, Q_MAX, 1'b0);
        send_sample(Q_MAX, Q_MAX, 1'b0);
        send_sample('0, '0, 1'b1);
        send_sample(Q_MIN, '0, 1'b0);
        send_sample(-32'sd1, '0, 1'b0);
        send_sample(32'sd1, '0, 1'b0);
        // a write to the unused index must leave every setting alone
        wait_loop_idle();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_sample(Q_ONE, '0, 1'b0);
    endtask

    // drive into the +-2.0 window, clear, reverse, then anti-windup off and clamp off
    task automatic test_windup_recovery();
        load_settings(Q_ONE, 32'sh0000_4000, 32'sh0002_0000, -32'sh0002_0000,
                      1'b1, 1'b1, 32'sh0000_8000);
        repeat (4) send_sample(32'sh000A_0000, '0, 1'b0);
        send_sample('0, '0, 1'b1);
        repeat (2) send_sample(-32'sh000A_0000, '0, 1'b0);
        wait_loop_idle();
        write_reg(REG_WINDUP_ENABLE, 32'd0);
        repeat (2) send_sample(32'sh000A_0000, '0, 1'b0);
        // anti-windup enabled but clamp off: no back-calculation
        wait_loop_idle();
        write_reg(REG_CLAMP_ENABLE, 32'd0);
        write_reg(REG_WINDUP_ENABLE, 32'd1);
        repeat (2) send_sample(32'sh000A_0000, '0, 1'b0);
    endtask

    // upper below lower, and half-lsb ties in the products
    task automatic test_crossed_limits_rounding();
        load_settings(32'sd1, Q_ONE, -Q_ONE, Q_ONE, 1'b1, 1'b0, '0);
        send_sample(32'sh0000_8000, '0, 1'b0);
        send_sample(-32'sh0000_8000, '0, 1'b0);
        send_sample(-32'sh0003_0000, '0, 1'b0);
        send_sample(-32'sh0000_8000, '0, 1'b0);
    endtask

    // phases of random settings; inside each, held setpoints with a tracking
    // measurement, plus clears and free-running noise
    task automatic test_random_phases();
        logic signed [31:0] setpoint, upper, lower, swap;
        int unsigned        hold, kind;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                load_settings(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1, 1'b1, Q_MIN);
            end else if (ph == 1) begin
                load_settings(Q_MIN, Q_MAX, '0, '0, 1'b1, 1'b1, Q_MAX);
            end else begin
                upper = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0008_0000;
                lower = upper - $signed($urandom_range(0, 32'h0020_0000));
                if ($urandom_range(0, 5) == 0) begin
                    swap  = upper;
                    upper = lower;
                    lower = swap;
                end
                if ($urandom_range(0, 7) == 0) upper = pick_extreme();
                if ($urandom_range(0, 7) == 0) lower = pick_extreme();
                load_settings(pick_gain(), pick_gain(), upper, lower,
                              ($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)),
                              pick_gain());
            end
            hold = 0;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (hold == 0) begin
                    setpoint = pick_sample();
                    hold     = $urandom_range(5, 30);
                end
                hold--;
                kind = $urandom_range(0, 19);
                if (kind == 0) begin
                    send_sample(pick_sample(), pick_sample(), 1'b1);
                end else if (kind <= 2) begin
                    send_sample(pick_sample(), pick_sample(), 1'b0);
                end else begin
                    // measurement close to the held setpoint
                    send_sample(setpoint,
                                setpoint - ($signed($urandom_range(0, 32'h0004_0000))
                                            - 32'sh0002_0000),
                                1'b0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        fail_count       = 0;
        cycle_count      = 0;
        send_calm        = 0;
        recv_calm        = 0;
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        s_valid          = 1'b0;
        s_reference      = '0;
        s_measured       = '0;
        s_clear_integral = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_power_up_defaults();
        test_saturating_extremes();
        test_windup_recovery();
        test_crossed_limits_rounding();
        test_random_phases();

        wait_loop_idle();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/pica_pkg.sv
src/pica_ctrl.sv
src/pica_dp.sv
src/pi_controller_antiwindup.sv
tb/pi_controller_antiwindup_tb.sv
